// ===== src/kvt_pkg.sv =====
// Shared constants, types and codes for the knob volume tracker.
`default_nettype none

package kvt_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 8;
    localparam int LEVEL_BITS    = SAMPLE_BITS + FRACTION_BITS;
    localparam int CUTOFF_BITS   = 12;
    localparam int WEIGHT_BITS   = 9;
    localparam int PROD_BITS     = LEVEL_BITS + WEIGHT_BITS;
    localparam int MUL_CNT_BITS  = $clog2(WEIGHT_BITS);
    localparam int VOL_BITS      = 7;
    localparam int SCALED_BITS   = LEVEL_BITS + 7;
    localparam int QUOT_BITS     = 9;
    localparam int DIV_STEPS     = 6;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = CUTOFF_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CUTOFF = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT = 1'b1;

    localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 12'd500;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 9'd26;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL  = 9'd256;

    localparam logic [VOL_BITS-1:0] VOL_MAX  = 7'd100;
    localparam logic [VOL_BITS-1:0] VOL_STEP = 7'd2;

    localparam logic [SCALED_BITS-1:0] SCALED_LOW  = SCALED_BITS'(5) << LEVEL_BITS;
    localparam logic [SCALED_BITS-1:0] SCALED_SPAN = SCALED_BITS'(90) << LEVEL_BITS;
    localparam logic [QUOT_BITS:0]     DIVISOR     = 10'd9;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_UP   = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DESCEND = 2'd1,
        PH_TRACK   = 2'd2
    } kvt_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SCALE,
        ST_QUOT,
        ST_DIV,
        ST_FINISH
    } kvt_state_t;

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample;
    } kvt_in_t;

    typedef struct packed {
        logic [1:0]          key;
        logic [VOL_BITS-1:0] host_volume;
        logic [VOL_BITS-1:0] target_volume;
    } kvt_out_t;

endpackage

`default_nettype wire

// ===== src/knob_volume_tracker.sv =====
// Knob volume tracker top level: smoothing, volume mapping and host key stepping.
//
// Input channel in_valid/in_stall/in_data carries one knob item: a sample tick
// (mode 0, with a 12-bit converter reading) or a resync request (mode 1).
// Output channel out_valid/out_stall/out_data returns one result per item:
// the key to send (none, up, down), the host volume estimate and the target.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high. Index 0 is the change cutoff, index 1 the smoothing weight.
// One item is in work at a time. A resync goes from idle straight to the finish
// state. A sample tick passes prep, the multiplier only when the change reaches
// the cutoff (outside the deadband), then scale, quotient setup, divide and
// finish: the bit-serial multiplier handles one weight bit per cycle (9 bits) and
// the volume divider one quotient bit per cycle (6 bits). Finish hands the result
// to the output register and returns to idle for the next item.
// The next item is taken once the result sits in the output register, even
// while the receiver stalls it; a stalled result holds until transferred, and a
// finished result waits in the tracker until the output register frees.
// Reset loads the cutoff with 500 and the weight with 26, clears the smoothed
// level and volumes, and leaves the tracking phase idle until the first resync.
`default_nettype none

module knob_volume_tracker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire kvt_pkg::kvt_in_t                    in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output kvt_pkg::kvt_out_t                        out_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [kvt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [kvt_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    kvt_pkg::kvt_state_t                 state_reg;
    kvt_pkg::kvt_state_t                 state_next;
    kvt_pkg::kvt_phase_t                 phase_reg;
    kvt_pkg::kvt_phase_t                 phase_next;
    logic                                seeded_reg;
    logic                                seeded_next;
    logic [kvt_pkg::LEVEL_BITS-1:0]      level_reg;
    logic [kvt_pkg::LEVEL_BITS-1:0]      level_next;
    logic [kvt_pkg::VOL_BITS-1:0]        host_reg;
    logic [kvt_pkg::VOL_BITS-1:0]        host_next;
    logic [kvt_pkg::VOL_BITS-1:0]        target_reg;
    logic [kvt_pkg::VOL_BITS-1:0]        target_next;
    logic [kvt_pkg::CUTOFF_BITS-1:0]     cutoff_reg;
    logic [kvt_pkg::CUTOFF_BITS-1:0]     cutoff_next;
    logic [kvt_pkg::WEIGHT_BITS-1:0]     weight_reg;
    logic [kvt_pkg::WEIGHT_BITS-1:0]     weight_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    kvt_pkg::kvt_out_t                   out_data_reg;
    kvt_pkg::kvt_out_t                   out_data_next;

    logic                                mode_reg;
    logic                                mode_next;
    logic [kvt_pkg::SAMPLE_BITS-1:0]     sample_reg;
    logic [kvt_pkg::SAMPLE_BITS-1:0]     sample_next;
    logic                                up_reg;
    logic                                up_next;
    logic [kvt_pkg::SCALED_BITS-1:0]     num_reg;
    logic [kvt_pkg::SCALED_BITS-1:0]     num_next;
    logic [kvt_pkg::QUOT_BITS-1:0]       rem_reg;
    logic [kvt_pkg::QUOT_BITS-1:0]       rem_next;
    logic [kvt_pkg::DIV_STEPS-1:0]       quo_reg;
    logic [kvt_pkg::DIV_STEPS-1:0]       quo_next;
    logic [kvt_pkg::DIV_CNT_BITS-1:0]    div_cnt_reg;
    logic [kvt_pkg::DIV_CNT_BITS-1:0]    div_cnt_next;

    logic                                mul_start;
    logic                                mul_done;
    logic [kvt_pkg::LEVEL_BITS-1:0]      mul_mcand;
    logic [kvt_pkg::WEIGHT_BITS-1:0]     mul_weight;
    logic [kvt_pkg::PROD_BITS-1:0]       mul_product;

    logic [kvt_pkg::LEVEL_BITS-1:0]      sample_level;
    logic [kvt_pkg::LEVEL_BITS-1:0]      step_level;
    logic [kvt_pkg::SCALED_BITS-1:0]     scaled;
    logic [kvt_pkg::SCALED_BITS-1:0]     num_raw;
    logic [kvt_pkg::SCALED_BITS+2:0]     num_times5;
    logic [kvt_pkg::QUOT_BITS:0]         trial;
    logic                                trial_ge;
    logic [kvt_pkg::VOL_BITS-1:0]        knob_volume;
    logic [kvt_pkg::VOL_BITS-1:0]        goal;
    logic                                in_xfer;
    logic                                out_free;

    kvt_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_weight),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        in_xfer      = in_valid && !in_stall;
        out_free     = !out_valid_reg || !out_stall;
        sample_level = {sample_reg, {kvt_pkg::FRACTION_BITS{1'b0}}};
        step_level   = mul_product[kvt_pkg::FRACTION_BITS +: kvt_pkg::LEVEL_BITS];
        scaled       = kvt_pkg::SCALED_BITS'(level_reg) * kvt_pkg::SCALED_BITS'(100);
        num_raw      = (scaled <= kvt_pkg::SCALED_LOW) ? '0 : scaled - kvt_pkg::SCALED_LOW;
        num_times5   = {num_reg, 2'b00} + (kvt_pkg::SCALED_BITS + 3)'(num_reg);
        trial        = kvt_pkg::DIVISOR << div_cnt_reg;
        trial_ge     = {1'b0, rem_reg} >= trial;
        knob_volume  = kvt_pkg::VOL_MAX - {quo_reg, 1'b0};
        goal         = (phase_reg == kvt_pkg::PH_TRACK) ? knob_volume : target_reg;

        mul_start  = 1'b0;
        mul_mcand  = (sample_level >= level_reg) ? sample_level - level_reg
                                                 : level_reg - sample_level;
        mul_weight = (weight_reg > kvt_pkg::WEIGHT_FULL) ? kvt_pkg::WEIGHT_FULL : weight_reg;

        state_next     = state_reg;
        phase_next     = phase_reg;
        seeded_next    = seeded_reg;
        level_next     = level_reg;
        host_next      = host_reg;
        target_next    = target_reg;
        cutoff_next    = cutoff_reg;
        weight_next    = weight_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mode_next      = mode_reg;
        sample_next    = sample_reg;
        up_next        = up_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kvt_pkg::CFG_CUTOFF: cutoff_next = cfg_data[kvt_pkg::CUTOFF_BITS-1:0];
                kvt_pkg::CFG_WEIGHT: weight_next = cfg_data[kvt_pkg::WEIGHT_BITS-1:0];
                default:             cutoff_next = cutoff_reg;
            endcase
        end

        case (state_reg)
            kvt_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next   = in_data.mode;
                    sample_next = in_data.sample;
                    if (in_data.mode)
                    begin
                        phase_next  = kvt_pkg::PH_DESCEND;
                        host_next   = kvt_pkg::VOL_MAX;
                        target_next = '0;
                        state_next  = kvt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        if (!seeded_reg)
                        begin
                            seeded_next = 1'b1;
                            level_next  = {in_data.sample, {kvt_pkg::FRACTION_BITS{1'b0}}};
                        end
                        state_next = kvt_pkg::ST_PREP;
                    end
                end
            end
            kvt_pkg::ST_PREP:
            begin
                up_next = sample_level >= level_reg;
                if (mul_mcand < {cutoff_reg, {kvt_pkg::FRACTION_BITS{1'b0}}})
                begin
                    state_next = kvt_pkg::ST_SCALE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = kvt_pkg::ST_MUL;
                end
            end
            kvt_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    level_next = up_reg ? level_reg + step_level : level_reg - step_level;
                    state_next = kvt_pkg::ST_SCALE;
                end
            end
            kvt_pkg::ST_SCALE:
            begin
                num_next   = (num_raw > kvt_pkg::SCALED_SPAN) ? kvt_pkg::SCALED_SPAN : num_raw;
                state_next = kvt_pkg::ST_QUOT;
            end
            kvt_pkg::ST_QUOT:
            begin
                rem_next     = num_times5[kvt_pkg::LEVEL_BITS +: kvt_pkg::QUOT_BITS];
                quo_next     = '0;
                div_cnt_next = kvt_pkg::DIV_CNT_BITS'(kvt_pkg::DIV_STEPS - 1);
                state_next   = kvt_pkg::ST_DIV;
            end
            kvt_pkg::ST_DIV:
            begin
                if (trial_ge)
                begin
                    rem_next = rem_reg - trial[kvt_pkg::QUOT_BITS-1:0];
                end
                quo_next = {quo_reg[kvt_pkg::DIV_STEPS-2:0], trial_ge};
                if (div_cnt_reg == '0)
                begin
                    state_next = kvt_pkg::ST_FINISH;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            kvt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = kvt_pkg::ST_IDLE;
                    if (mode_reg)
                    begin
                        out_data_next.key           = kvt_pkg::KEY_NONE;
                        out_data_next.host_volume   = host_reg;
                        out_data_next.target_volume = target_reg;
                    end
                    else
                    begin
                        out_data_next.key = kvt_pkg::KEY_NONE;
                        target_next       = goal;
                        if (host_reg > goal)
                        begin
                            host_next         = (host_reg >= kvt_pkg::VOL_STEP)
                                                ? host_reg - kvt_pkg::VOL_STEP : '0;
                            out_data_next.key = kvt_pkg::KEY_DOWN;
                        end
                        else if (host_reg < goal)
                        begin
                            host_next         = host_reg + kvt_pkg::VOL_STEP;
                            out_data_next.key = kvt_pkg::KEY_UP;
                        end
                        else if (phase_reg == kvt_pkg::PH_DESCEND)
                        begin
                            phase_next  = kvt_pkg::PH_TRACK;
                            target_next = knob_volume;
                        end
                        out_data_next.host_volume   = host_next;
                        out_data_next.target_volume = target_next;
                    end
                end
            end
            default:
            begin
                state_next = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvt_pkg::ST_IDLE;
            phase_reg     <= kvt_pkg::PH_IDLE;
            seeded_reg    <= 1'b0;
            level_reg     <= '0;
            host_reg      <= '0;
            target_reg    <= '0;
            cutoff_reg    <= kvt_pkg::CUTOFF_RESET;
            weight_reg    <= kvt_pkg::WEIGHT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            seeded_reg    <= seeded_next;
            level_reg     <= level_next;
            host_reg      <= host_next;
            target_reg    <= target_next;
            cutoff_reg    <= cutoff_next;
            weight_reg    <= weight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        mode_reg     <= mode_next;
        sample_reg   <= sample_next;
        up_reg       <= up_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_cnt_reg  <= div_cnt_next;
    end

    assign in_stall  = (state_reg != kvt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== src/kvt_serial_mul.sv =====
// Bit-serial shift-and-add multiplier for the smoothing step.
`default_nettype none

module kvt_serial_mul (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [kvt_pkg::LEVEL_BITS-1:0]   mcand,
    input  wire logic [kvt_pkg::WEIGHT_BITS-1:0]  mplier,
    output logic                                  done,
    output logic [kvt_pkg::PROD_BITS-1:0]         product
);

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [kvt_pkg::MUL_CNT_BITS-1:0]   cnt_reg;
    logic [kvt_pkg::MUL_CNT_BITS-1:0]   cnt_next;
    logic [kvt_pkg::PROD_BITS-1:0]      mcand_reg;
    logic [kvt_pkg::PROD_BITS-1:0]      mcand_next;
    logic [kvt_pkg::WEIGHT_BITS-1:0]    mplier_reg;
    logic [kvt_pkg::WEIGHT_BITS-1:0]    mplier_next;
    logic [kvt_pkg::PROD_BITS-1:0]      acc_reg;
    logic [kvt_pkg::PROD_BITS-1:0]      acc_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            mcand_next  = kvt_pkg::PROD_BITS'(mcand);
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == kvt_pkg::MUL_CNT_BITS'(kvt_pkg::WEIGHT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ===== tb/sv/kvt_tb_pkg.sv =====
// Item mode codes shared by the knob volume tracker stimulus and checker.
`timescale 1ns / 1ps

package kvt_tb_pkg;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_RESYNC = 1'b1;

endpackage

// ===== tb/sv/knob_volume_check.sv =====
// Checker for the knob volume tracker: predicts each result and compares transfers.
`timescale 1ns / 1ps

module knob_volume_check
    import kvt_pkg::*;
    import kvt_tb_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire kvt_in_t                   in_data,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire kvt_out_t                  out_data,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                             mismatch_count,
    output int                             outstanding
);

    kvt_out_t               expected_q[$];
    int                     fail_total;
    logic                   seen_sample;
    logic [LEVEL_BITS-1:0]  knob_level;
    logic [VOL_BITS-1:0]    host_est;
    logic [VOL_BITS-1:0]    target_est;
    kvt_phase_t             track_phase;
    logic [CUTOFF_BITS-1:0] cutoff_cfg;
    logic [WEIGHT_BITS-1:0] weight_cfg;

    function automatic logic [VOL_BITS-1:0] volume_of_level(logic [LEVEL_BITS-1:0] lvl);
        longint unsigned full_scale;
        longint unsigned scaled;
        longint unsigned notch;
        full_scale = 64'd1 << LEVEL_BITS;
        scaled = 64'(lvl) * 100;
        if (scaled <= full_scale * 5)
            scaled = 0;
        else
            scaled = scaled - full_scale * 5;
        if (scaled > full_scale * 90)
            scaled = full_scale * 90;
        notch = (scaled * 5) / (full_scale * 9);
        return VOL_MAX - VOL_BITS'(notch * VOL_STEP);
    endfunction

    task automatic smooth_toward(logic [SAMPLE_BITS-1:0] raw);
        longint unsigned aim;
        longint unsigned level;
        longint unsigned gap;
        longint unsigned weight;
        longint unsigned shift;
        aim = 64'(raw) << FRACTION_BITS;
        if (!seen_sample)
        begin
            seen_sample = 1'b1;
            knob_level = LEVEL_BITS'(aim);
        end
        level = 64'(knob_level);
        weight = (weight_cfg > WEIGHT_FULL) ? 64'(WEIGHT_FULL) : 64'(weight_cfg);
        gap = (aim >= level) ? aim - level : level - aim;
        if (gap >= (64'(cutoff_cfg) << FRACTION_BITS))
        begin
            shift = (gap * weight) / 64'(WEIGHT_FULL);
            if (aim >= level)
                knob_level = LEVEL_BITS'(level + shift);
            else
                knob_level = LEVEL_BITS'(level - shift);
        end
    endtask

    task automatic advance_tracker(kvt_in_t item, output kvt_out_t res);
        res.key = KEY_NONE;
        if (item.mode == MODE_RESYNC)
        begin
            track_phase = PH_DESCEND;
            host_est = VOL_MAX;
            target_est = '0;
        end
        else
        begin
            smooth_toward(item.sample);
            if (track_phase == PH_TRACK)
                target_est = volume_of_level(knob_level);
            if (host_est > target_est)
            begin
                host_est = (host_est >= VOL_STEP) ? host_est - VOL_STEP : '0;
                res.key = KEY_DOWN;
            end
            else if (host_est < target_est)
            begin
                host_est = host_est + VOL_STEP;
                res.key = KEY_UP;
            end
            else if (track_phase == PH_DESCEND)
            begin
                track_phase = PH_TRACK;
                target_est = volume_of_level(knob_level);
            end
        end
        res.host_volume = host_est;
        res.target_volume = target_est;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        kvt_out_t want;
        kvt_out_t got;
        if (!rst_n)
        begin
            expected_q.delete();
            fail_total = 0;
            seen_sample = 1'b0;
            knob_level = '0;
            host_est = '0;
            target_est = '0;
            track_phase = PH_IDLE;
            cutoff_cfg = CUTOFF_RESET;
            weight_cfg = WEIGHT_RESET;
            mismatch_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CUTOFF: cutoff_cfg = cfg_data[CUTOFF_BITS-1:0];
                    CFG_WEIGHT: weight_cfg = cfg_data[WEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (expected_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result transfer: key=%0d host=%0d target=%0d",
                                 got.key, got.host_volume, got.target_volume);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.key !== want.key || got.host_volume !== want.host_volume ||
                        got.target_volume !== want.target_volume)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("mismatch: expected key=%0d host=%0d target=%0d, got key=%0d host=%0d target=%0d",
                                     want.key, want.host_volume, want.target_volume,
                                     got.key, got.host_volume, got.target_volume);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_tracker(in_data, want);
                expected_q.push_back(want);
            end
            mismatch_count <= fail_total;
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== tb/sv/knob_volume_tracker_test.sv =====
// Testbench top for the knob volume tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module knob_volume_tracker_test;
    import kvt_pkg::*;
    import kvt_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 300;
    localparam int PAD_BITS     = CFG_DATA_BITS - WEIGHT_BITS;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    kvt_in_t                   in_data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    kvt_out_t                  out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int knob_pos = 2048;
    int cycle_count = 0;
    int mismatch_count;
    int outstanding;

    knob_volume_tracker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    knob_volume_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("knob_volume_tracker verification failed");
            $finish;
        end
    end

    task automatic send_item(logic mode_bit, logic [SAMPLE_BITS-1:0] sample_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= kvt_in_t'{mode: mode_bit, sample: sample_val};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] wander_knob();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            knob_pos = $urandom_range(4095);
        else if (pick < 14)
            knob_pos = $urandom_range(1) * 4095;
        else if (pick < 60)
            knob_pos = knob_pos + int'($urandom_range(1400)) - 700;
        else
            knob_pos = knob_pos + int'($urandom_range(60)) - 30;
        if (knob_pos < 0)
            knob_pos = 0;
        if (knob_pos > 4095)
            knob_pos = 4095;
        return SAMPLE_BITS'(knob_pos);
    endfunction

    task automatic run_phase(logic [CUTOFF_BITS-1:0] cutoff, logic [WEIGHT_BITS-1:0] weight,
                             int send_pct, int stall_rate, int count);
        drain();
        write_reg(CFG_CUTOFF, cutoff);
        write_reg(CFG_WEIGHT, {PAD_BITS'($urandom_range((1 << PAD_BITS) - 1)), weight});
        cfg_valid <= 1'b0;
        send_idle_pct = send_pct;
        stall_pct = stall_rate;
        repeat (count)
        begin
            if ($urandom_range(99) < 2)
                send_item(MODE_RESYNC, SAMPLE_BITS'($urandom_range(4095)));
            else
                send_item(MODE_TICK, wander_knob());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_TICK, 12'd4095);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_TICK, 12'd2048);
        send_item(MODE_TICK, 12'd2300);
        send_item(MODE_RESYNC, 12'd4095);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_TICK, 12'd4095);
        send_item(MODE_TICK, 12'd4095);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_RESYNC, 12'd0);
        send_item(MODE_TICK, 12'd1);
        send_item(MODE_TICK, 12'd4094);
        send_item(MODE_TICK, 12'd2730);
        send_item(MODE_TICK, 12'd1365);
        send_item(MODE_TICK, 12'd100);
        send_item(MODE_TICK, 12'd3995);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_TICK, 12'd0);
        send_item(MODE_TICK, 12'd4095);
        send_item(MODE_TICK, 12'd4095);

        run_phase(CUTOFF_RESET, WEIGHT_RESET, 0, 0, PHASE_ITEMS);
        run_phase('0, WEIGHT_FULL, 68, 0, PHASE_ITEMS);
        run_phase('1, 9'd1, 0, 68, PHASE_ITEMS);
        run_phase(CUTOFF_BITS'($urandom_range(800)), '1, 28, 28, PHASE_ITEMS);
        run_phase(CUTOFF_BITS'($urandom_range(800)), '0, 0, 0, PHASE_ITEMS);
        run_phase(CUTOFF_BITS'($urandom_range(4095)), WEIGHT_BITS'($urandom_range(256, 1)),
                  28, 28, PHASE_ITEMS);
        drain();

        if (mismatch_count == 0)
            $display("knob_volume_tracker verification clean");
        else
            $display("knob_volume_tracker verification failed");
        $finish;
    end

endmodule
